### rtl/lba_to_chs_with_seek_tracking_macros.svh
// Assertion macros shared by the checker of the LBA to CHS translator.
`ifndef LBA_TO_CHS_WITH_SEEK_TRACKING_MACROS_SVH
`define LBA_TO_CHS_WITH_SEEK_TRACKING_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define L2CHS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define L2CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/l2chs_pkg.sv
// Types and constants of the LBA to CHS translator.
package l2chs_pkg;

	localparam int LBA_FIELD_W = 32;
	localparam int STATUS_W    = 16;
	localparam int DVS_W       = 16;
	localparam int SECT_DIV_STEPS = 16;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_TRANSLATE = 2'd0;
	localparam logic [1:0] OP_COMPLETE  = 2'd1;
	localparam logic [1:0] OP_RECAL     = 2'd2;

	// Result codes.
	localparam logic [1:0] RC_OK        = 2'd0;
	localparam logic [1:0] RC_ERROR     = 2'd1;
	localparam logic [1:0] RC_WPROT     = 2'd2;
	localparam logic [1:0] RC_CYL_RANGE = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_SPT   = 2'd0;
	localparam logic [1:0] REG_HEADS = 2'd1;
	localparam logic [1:0] REG_FSN   = 2'd2;

	localparam logic [7:0] SPT_RESET   = 8'd18;
	localparam logic [7:0] HEADS_RESET = 8'd2;
	localparam logic       FSN_RESET   = 1'b1;

	// Floppy command bytes.
	localparam logic [7:0] CMD_WRITE_MFM = 8'h45;
	localparam logic [7:0] CMD_READ_MFM  = 8'h46;
	localparam logic [7:0] CMD_SEEK_BIT  = 8'h10;

	// Top nibble of the controller status word.
	localparam logic [3:0] STAT_FAIL   = 4'h1;
	localparam logic [3:0] STAT_WPROT  = 4'h7;

	typedef struct packed {
		logic [7:0] cylinder;
		logic [7:0] head;
		logic [7:0] sector;
		logic [7:0] command_byte;
		logic       seek_needed;
		logic [1:0] result_code;
	} l2chs_result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} l2chs_div_stat_t;

endpackage

### rtl/l2chs_if.sv
// Channel interfaces of the LBA to CHS translator: requests, results and configuration.
interface l2chs_req_if import l2chs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             operation;
	logic [LBA_FIELD_W-1:0] lba;
	logic                   is_write;
	logic [STATUS_W-1:0]    status_word;
	logic                   carry_error;

	modport source (output valid, operation, lba, is_write, status_word, carry_error,
		input ready);
	modport sink (input valid, operation, lba, is_write, status_word, carry_error,
		output ready);
endinterface

interface l2chs_rsp_if import l2chs_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] cylinder;
	logic [7:0] head;
	logic [7:0] sector;
	logic [7:0] command_byte;
	logic       seek_needed;
	logic [1:0] result_code;

	modport source (output valid, cylinder, head, sector, command_byte, seek_needed,
		result_code, input ready);
	modport sink (input valid, cylinder, head, sector, command_byte, seek_needed,
		result_code, output ready);
endinterface

interface l2chs_cfg_if import l2chs_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/lba_to_chs_with_seek_tracking.sv
// LBA to cylinder/head/sector translator with floppy seek tracking, top level.
//
// Requests arrive on req, results leave on rsp, and geometry registers are written
// on cfg (index 0 sectors per track, 1 heads, 2 first sector number). Every request
// transaction yields exactly one result transaction, in order.
// A translate request first multiplies out the sectors per cylinder and then
// runs two divisions through one shared bit-serial divider: a full-width division for the
// cylinder and a 16-bit one for head and sector. The translate result is built in the
// staging register and then moved to the output register; no new request is taken
// before that move. Completion, recalibrate and rejected requests need no division:
// their result goes through the same two registers.
// req.ready is high only while no request is in progress, so one request is handled
// at a time. A finished result sits in the output register until rsp.ready takes it;
// meanwhile the next request is accepted and worked on, and it waits in a staging
// register only if the previous result still has not been taken.
// After reset the geometry is 18 sectors, 2 heads, first sector 1, and the track
// position is unknown, so the first translate asks for a seek.
// cfg.ready is always high; registers are to be written only while the block is idle.
module lba_to_chs_with_seek_tracking import l2chs_pkg::*; #(
	parameter int LBA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	l2chs_cfg_if.sink   cfg,
	l2chs_req_if.sink   req,
	l2chs_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(LBA_WIDTH+1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_DIV2 = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0]           state_q;
	logic                 start_q;
	logic                 out_vld_q;
	logic [7:0]           spt_q;
	logic [7:0]           heads_q;
	logic                 fsn_q;
	logic                 track_known_q;
	logic [7:0]           head_track_q;
	logic [7:0]           pending_cyl_q;

	logic [LBA_WIDTH-1:0] lba_q;
	logic                 wr_q;
	logic [DVS_W-1:0]     spc_q;
	logic [LBA_WIDTH-1:0] cyl_q;
	logic [DVS_W-1:0]     hs_q;
	l2chs_result_t        stg_q;
	l2chs_result_t        out_q;

	logic                 req_fire;
	logic                 cfg_fire;
	logic                 bad_geom;
	logic [3:0]           stat_nib;
	logic                 cpl_err;
	logic [1:0]           cpl_code;
	logic                 div2_done;
	logic                 cyl_over;
	logic [7:0]           cyl_sat;
	logic                 seek;
	logic [7:0]           cmd_base;
	logic                 out_load;
	l2chs_result_t        imm_res;
	l2chs_result_t        xlat_res;

	logic                 div_start;
	logic [CNT_W-1:0]     div_steps;
	logic [LBA_WIDTH-1:0] div_dvd;
	logic [DVS_W-1:0]     div_dvs;
	l2chs_div_stat_t      div_stat;
	logic [LBA_WIDTH-1:0] div_quo;
	logic [DVS_W-1:0]     div_rem;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid & req.ready;
	assign cfg_fire  = cfg.valid & cfg.ready;
	assign bad_geom  = (spt_q == 8'd0) | (heads_q == 8'd0);
	assign out_load  = (state_q == ST_RESP) & (~out_vld_q | rsp.ready);

	// Completion status decode.
	assign stat_nib = req.status_word[STATUS_W-1 -: 4];
	assign cpl_err  = req.carry_error | (stat_nib == STAT_FAIL);
	assign cpl_code = ~cpl_err ? RC_OK :
		(req.is_write & req.carry_error & (stat_nib == STAT_WPROT)) ? RC_WPROT : RC_ERROR;

	// Results that need no division.
	always_comb begin
		imm_res = '0;
		case (req.operation)
			OP_TRANSLATE: imm_res.result_code = RC_ERROR;
			OP_COMPLETE: begin
				imm_res.cylinder    = pending_cyl_q;
				imm_res.result_code = cpl_code;
			end
			OP_RECAL: imm_res.result_code = RC_OK;
			default: imm_res.result_code = RC_ERROR;
		endcase
	end

	// Translate result, formed when the head/sector division finishes.
	assign div2_done = (state_q == ST_DIV2) & div_stat.done;
	assign cyl_over  = |cyl_q[LBA_WIDTH-1:8];
	assign cyl_sat   = cyl_over ? 8'hff : cyl_q[7:0];
	assign seek      = cyl_over | ~track_known_q | (head_track_q != cyl_q[7:0]);
	assign cmd_base  = wr_q ? CMD_WRITE_MFM : CMD_READ_MFM;

	always_comb begin
		xlat_res.cylinder     = cyl_sat;
		xlat_res.head         = div_quo[7:0];
		xlat_res.sector       = div_rem[7:0] + {7'd0, fsn_q};
		xlat_res.command_byte = seek ? (cmd_base | CMD_SEEK_BIT) : cmd_base;
		xlat_res.seek_needed  = seek;
		xlat_res.result_code  = cyl_over ? RC_CYL_RANGE : RC_OK;
	end

	// First pass divides the LBA by sectors per cylinder; the second divides the
	// remainder, moved to the top of the dividend, by sectors per track.
	assign div_start = start_q;
	assign div_steps = (state_q == ST_DIV2) ? CNT_W'(SECT_DIV_STEPS) : CNT_W'(LBA_WIDTH);
	assign div_dvd   = (state_q == ST_DIV2) ?
		(LBA_WIDTH'(hs_q) << (LBA_WIDTH - SECT_DIV_STEPS)) : lba_q;
	assign div_dvs   = (state_q == ST_DIV2) ? {8'd0, spt_q} : spc_q;

	l2chs_div #(
		.DVD_W (LBA_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.steps     (div_steps),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			start_q       <= 1'b0;
			out_vld_q     <= 1'b0;
			spt_q         <= SPT_RESET;
			heads_q       <= HEADS_RESET;
			fsn_q         <= FSN_RESET;
			track_known_q <= 1'b0;
			head_track_q  <= 8'd0;
			pending_cyl_q <= 8'd0;
		end else begin
			start_q <= 1'b0;
			if (cfg_fire) begin
				case (cfg.index)
					REG_SPT:   spt_q   <= cfg.data;
					REG_HEADS: heads_q <= cfg.data;
					REG_FSN:   fsn_q   <= cfg.data[0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.operation == OP_TRANSLATE && !bad_geom) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_RESP;
						end
						if (req.operation == OP_COMPLETE && !cpl_err) begin
							head_track_q  <= pending_cyl_q;
							track_known_q <= 1'b1;
						end
						if (req.operation == OP_RECAL) begin
							track_known_q <= 1'b0;
						end
					end
				end
				ST_MUL: begin
					start_q <= 1'b1;
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_stat.done) begin
						start_q <= 1'b1;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_stat.done) begin
						if (!cyl_over) begin
							pending_cyl_q <= cyl_q[7:0];
						end
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			lba_q <= req.lba[LBA_WIDTH-1:0];
			wr_q  <= req.is_write;
			stg_q <= imm_res;
		end
		if (state_q == ST_MUL) begin
			spc_q <= spt_q * heads_q;
		end
		if ((state_q == ST_DIV1) && div_stat.done) begin
			cyl_q <= div_quo;
			hs_q  <= div_rem;
		end
		if (div2_done) begin
			stg_q <= xlat_res;
		end
		if (out_load) begin
			out_q <= stg_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.cylinder     = out_q.cylinder;
	assign rsp.head         = out_q.head;
	assign rsp.sector       = out_q.sector;
	assign rsp.command_byte = out_q.command_byte;
	assign rsp.seek_needed  = out_q.seek_needed;
	assign rsp.result_code  = out_q.result_code;

endmodule

### rtl/l2chs_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions of a request.
module l2chs_div import l2chs_pkg::*; #(
	parameter int DVD_W = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [$clog2(DVD_W+1)-1:0]   steps,
	input  logic [DVD_W-1:0]             dividend,
	input  logic [DVS_W-1:0]             divisor,
	output l2chs_div_stat_t              stat,
	output logic [DVD_W-1:0]             quotient,
	output logic [DVS_W-1:0]             remainder
);

	localparam int CNT_W = $clog2(DVD_W+1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W+1:0] diff;
	logic             ge;
	logic [DVS_W-1:0] rem_nxt;

	// The dividend is consumed from its top bit; its freed low bits collect the quotient.
	assign diff    = {1'b0, rem_q, quo_q[DVD_W-1]} - {2'b00, divisor};
	assign ge      = ~diff[DVS_W+1];
	assign rem_nxt = ge ? diff[DVS_W-1:0] : {rem_q[DVS_W-2:0], quo_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/l2chs_checker.sv
// Port-level assertions for the LBA to CHS translator and their binding to the top level.
`include "lba_to_chs_with_seek_tracking_macros.svh"

module l2chs_checker import l2chs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] cylinder,
	input logic [7:0] head,
	input logic [7:0] sector,
	input logic [7:0] command_byte,
	input logic       seek_needed,
	input logic [1:0] result_code
);

	// A stalled result transaction keeps its payload.
	`L2CHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable({cylinder, head, sector, command_byte, seek_needed, result_code}),
		"result payload changed while stalled")

	// Only one request is worked on at a time.
	`L2CHS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
		"request accepted while another is in progress")

	// The seek bit of the command byte always agrees with the seek flag.
	`L2CHS_ASSERT_NOW(a_seek_bit, rsp_valid, command_byte[4] == seek_needed,
		"command seek bit disagrees with seek flag")

	// An out-of-range cylinder is saturated and always asks for a seek.
	`L2CHS_ASSERT_NOW(a_cyl_range, rsp_valid && result_code == RC_CYL_RANGE,
		cylinder == 8'hff && seek_needed,
		"out-of-range cylinder not saturated or no seek")

endmodule

bind lba_to_chs_with_seek_tracking l2chs_checker u_l2chs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.cylinder     (rsp.cylinder),
	.head         (rsp.head),
	.sector       (rsp.sector),
	.command_byte (rsp.command_byte),
	.seek_needed  (rsp.seek_needed),
	.result_code  (rsp.result_code)
);

### tb/tb_top.sv
// Self-checking testbench for the LBA to cylinder/head/sector translator with seek tracking.
`timescale 1ns / 100ps

module tb_top;
	import l2chs_pkg::*;

	// The block treats this code as an unknown operation and rejects it.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 60;
	localparam int HOLD_CYCLES    = 400;
	localparam int NUM_PHASES     = 10;
	localparam int PRESSURE_PHASE = 5;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] lba;
		logic        wr;
		logic [15:0] status;
		logic        carry;
	} disk_req_t;

	class chs_scoreboard;
		logic [7:0] geo_spt;
		logic [7:0] geo_heads;
		logic       geo_first;
		logic       trk_valid;
		logic [7:0] trk_cyl;
		logic [7:0] pend_cyl;
		l2chs_result_t chs_due[$];
		int faults;
		int checked;
		int seeks;
		int rc_count[4];

		function new();
			geo_spt   = SPT_RESET;
			geo_heads = HEADS_RESET;
			geo_first = FSN_RESET;
			trk_valid = 1'b0;
			trk_cyl   = 8'd0;
			pend_cyl  = 8'd0;
			faults    = 0;
			checked   = 0;
			seeks     = 0;
			rc_count  = '{0, 0, 0, 0};
		endfunction

		function void set_register(logic [1:0] idx, logic [7:0] value);
			case (idx)
				REG_SPT:   geo_spt   = value;
				REG_HEADS: geo_heads = value;
				REG_FSN:   geo_first = value[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return chs_due.size();
		endfunction

		// Works out the result of an accepted request and advances the track state.
		function void note_request(disk_req_t r);
			l2chs_result_t e;
			logic [15:0] per_cyl;
			logic [31:0] cyl_full;
			logic [15:0] rem;
			e = '0;
			case (r.op)
				OP_TRANSLATE: begin
					if (geo_spt == 8'd0 || geo_heads == 8'd0) begin
						e.result_code = RC_ERROR;
					end else begin
						per_cyl  = {8'd0, geo_spt} * {8'd0, geo_heads};
						cyl_full = r.lba / {16'd0, per_cyl};
						rem      = 16'(r.lba % {16'd0, per_cyl});
						e.head   = 8'(rem / {8'd0, geo_spt});
						e.sector = 8'(rem % {8'd0, geo_spt}) + {7'd0, geo_first};
						e.command_byte = r.wr ? CMD_WRITE_MFM : CMD_READ_MFM;
						if (cyl_full > 32'd255) begin
							e.cylinder    = 8'hff;
							e.seek_needed = 1'b1;
							e.result_code = RC_CYL_RANGE;
						end else begin
							e.cylinder    = cyl_full[7:0];
							e.seek_needed = !trk_valid || trk_cyl != cyl_full[7:0];
							e.result_code = RC_OK;
							pend_cyl      = cyl_full[7:0];
						end
						if (e.seek_needed)
							e.command_byte = e.command_byte | CMD_SEEK_BIT;
					end
				end
				OP_COMPLETE: begin
					e.cylinder = pend_cyl;
					if (r.carry || r.status[15:12] == STAT_FAIL) begin
						e.result_code = (r.wr && r.carry && r.status[15:12] == STAT_WPROT) ?
							RC_WPROT : RC_ERROR;
					end else begin
						trk_cyl   = pend_cyl;
						trk_valid = 1'b1;
					end
				end
				OP_RECAL: trk_valid = 1'b0;
				default: e.result_code = RC_ERROR;
			endcase
			chs_due.push_back(e);
		endfunction

		function void check_result(l2chs_result_t got);
			l2chs_result_t want;
			if (chs_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("Unexpected result: cyl %h hd %h sec %h cmd %h seek %b rc %0d",
						got.cylinder, got.head, got.sector, got.command_byte,
						got.seek_needed, got.result_code);
				return;
			end
			want = chs_due.pop_front();
			checked++;
			if (want.seek_needed)
				seeks++;
			rc_count[want.result_code]++;
			if (got.cylinder !== want.cylinder || got.head !== want.head ||
					got.sector !== want.sector || got.command_byte !== want.command_byte ||
					got.seek_needed !== want.seek_needed ||
					got.result_code !== want.result_code) begin
				faults++;
				if (faults <= 10) begin
					$display("Mismatch on result %0d:", checked);
					$display("  expected cyl %h hd %h sec %h cmd %h seek %b rc %0d",
						want.cylinder, want.head, want.sector, want.command_byte,
						want.seek_needed, want.result_code);
					$display("  actual   cyl %h hd %h sec %h cmd %h seek %b rc %0d",
						got.cylinder, got.head, got.sector, got.command_byte,
						got.seek_needed, got.result_code);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	l2chs_cfg_if cfg_ch ();
	l2chs_req_if req_ch ();
	l2chs_rsp_if rsp_ch ();

	lba_to_chs_with_seek_tracking uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	chs_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rsp_hold      = 0;
	int quiet_cycles  = 0;
	int sent          = 0;
	logic [31:0] last_lba = 32'd0;

	// A value of -1 picks a random legal setting for that phase.
	int phase_spt[NUM_PHASES]   = '{18, 1, -1, 255, 0, 255, 9, 1, -1, -1};
	int phase_heads[NUM_PHASES] = '{2, 1, -1, 255, 2, 1, 0, 255, -1, -1};
	int phase_first[NUM_PHASES] = '{1, 0, -1, 1, 1, 0, 0, 1, -1, -1};
	int phase_items[NUM_PHASES] = '{90, 90, 80, 90, 12, 80, 12, 80, 80, 80};

	always #1 clk = ~clk;

	function automatic disk_req_t mk_req(input logic [1:0] op, input logic [31:0] lba,
			input logic wr, input logic [15:0] status, input logic carry);
		disk_req_t r;
		r.op     = op;
		r.lba    = lba;
		r.wr     = wr;
		r.status = status;
		r.carry  = carry;
		return r;
	endfunction

	// Mostly in-range cylinders, with a share near the cylinder limit and in the
	// cylinder just used, so that both seek outcomes and saturation are reached.
	function automatic logic [31:0] pick_lba();
		int unsigned per_cyl;
		int sel;
		logic [31:0] v;
		per_cyl = sb.geo_spt * sb.geo_heads;
		sel = $urandom_range(0, 99);
		if (per_cyl == 0 || sel >= 85)
			v = $urandom;
		else if (sel < 55)
			v = $urandom_range(0, per_cyl * 256 - 1);
		else if (sel < 72)
			v = per_cyl * 255 + $urandom_range(0, 2 * per_cyl - 1);
		else
			v = last_lba + $urandom_range(0, 3);
		last_lba = v;
		return v;
	endfunction

	function automatic logic [15:0] pick_status();
		logic [15:0] s;
		s = 16'($urandom);
		case ($urandom_range(0, 3))
			0: s[15:12] = STAT_FAIL;
			1: s[15:12] = STAT_WPROT;
			2: s[15:12] = 4'h0;
			default: ;
		endcase
		return s;
	endfunction

	// Each cycle the sender stays idle with the chance given by send_idle_pct.
	function automatic int pick_gap();
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		return gap;
	endfunction

	task automatic send_request(input disk_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= r.op;
		req_ch.lba         <= r.lba;
		req_ch.is_write    <= r.wr;
		req_ch.status_word <= r.status;
		req_ch.carry_error <= r.carry;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
		sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [7:0] spt, input logic [7:0] heads,
			input logic first);
		logic [1:0] idx[3];
		logic [7:0] val[3];
		idx = '{REG_SPT, REG_HEADS, REG_FSN};
		val = '{spt, heads, {7'd0, first}};
		cfg_ch.valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
			sb.set_register(idx[i], val[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly a translate followed by its completion, with recalibrates, stray
	// completions and rejected operations mixed in.
	task automatic run_traffic(input int n);
		int done;
		int pick;
		logic w;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			w = 1'($urandom_range(0, 1));
			if (pick < 70) begin
				send_request(mk_req(OP_TRANSLATE, pick_lba(), w, 16'($urandom),
					1'($urandom_range(0, 1))));
				send_request(mk_req(OP_COMPLETE, $urandom, w, pick_status(),
					$urandom_range(0, 3) == 0));
				done += 2;
			end else begin
				if (pick < 80)
					send_request(mk_req(OP_TRANSLATE, pick_lba(), w, 16'($urandom),
						1'($urandom_range(0, 1))));
				else if (pick < 88)
					send_request(mk_req(OP_RECAL, $urandom, w, 16'($urandom),
						1'($urandom_range(0, 1))));
				else if (pick < 95)
					send_request(mk_req(OP_COMPLETE, $urandom, w, pick_status(),
						1'($urandom_range(0, 1))));
				else
					send_request(mk_req(OP_UNKNOWN, $urandom, w, 16'($urandom),
						1'($urandom_range(0, 1))));
				done++;
			end
		end
	endtask

	// Result side: checks each transaction and decides ready for the next edge.
	initial begin
		l2chs_result_t got;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.cylinder     = rsp_ch.cylinder;
				got.head         = rsp_ch.head;
				got.sector       = rsp_ch.sector;
				got.command_byte = rsp_ch.command_byte;
				got.seek_needed  = rsp_ch.seek_needed;
				got.result_code  = rsp_ch.result_code;
				sb.check_result(got);
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("No transaction for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, sb.pending());
		$display("FAILURE");
		$finish;
	end

	initial begin
		int saved_pct;
		logic [7:0] spt_v;
		logic [7:0] heads_v;
		logic first_v;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.operation    <= OP_TRANSLATE;
		req_ch.lba          <= '0;
		req_ch.is_write     <= 1'b0;
		req_ch.status_word  <= '0;
		req_ch.carry_error  <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_SPT;
		cfg_ch.data         <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 68;

		// Directed part at the reset geometry of 18 sectors and 2 heads.
		send_request(mk_req(OP_TRANSLATE, 32'd0, 1'b0, 16'h0000, 1'b0));
		send_request(mk_req(OP_COMPLETE, 32'd0, 1'b0, 16'h0000, 1'b0));
		send_request(mk_req(OP_TRANSLATE, 32'd17, 1'b0, 16'hffff, 1'b1));
		send_request(mk_req(OP_TRANSLATE, 32'd36, 1'b1, 16'h0000, 1'b0));
		send_request(mk_req(OP_COMPLETE, 32'd0, 1'b1, 16'h7000, 1'b1));
		send_request(mk_req(OP_COMPLETE, 32'd0, 1'b0, 16'h7abc, 1'b1));
		send_request(mk_req(OP_COMPLETE, 32'd0, 1'b1, 16'h1fff, 1'b0));
		send_request(mk_req(OP_COMPLETE, 32'hffffffff, 1'b1, 16'hffff, 1'b0));
		send_request(mk_req(OP_TRANSLATE, 32'd36, 1'b1, 16'h0000, 1'b0));
		send_request(mk_req(OP_RECAL, 32'hffffffff, 1'b1, 16'hffff, 1'b1));
		send_request(mk_req(OP_TRANSLATE, 32'd37, 1'b0, 16'h0000, 1'b0));
		send_request(mk_req(OP_TRANSLATE, 32'hffffffff, 1'b1, 16'hffff, 1'b1));
		send_request(mk_req(OP_COMPLETE, 32'd0, 1'b0, 16'h2000, 1'b0));
		send_request(mk_req(OP_TRANSLATE, 32'd9215, 1'b0, 16'h0000, 1'b0));
		send_request(mk_req(OP_TRANSLATE, 32'd9216, 1'b0, 16'h0000, 1'b0));
		send_request(mk_req(OP_UNKNOWN, 32'hffffffff, 1'b1, 16'hffff, 1'b1));
		send_request(mk_req(OP_COMPLETE, 32'd0, 1'b1, 16'h7000, 1'b0));
		send_request(mk_req(OP_TRANSLATE, 32'd9215, 1'b1, 16'h0000, 1'b0));
		send_request(mk_req(OP_RECAL, 32'd0, 1'b0, 16'h0000, 1'b0));
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			spt_v   = (phase_spt[p] < 0) ? 8'($urandom_range(1, 255)) : 8'(phase_spt[p]);
			heads_v = (phase_heads[p] < 0) ? 8'($urandom_range(1, 255)) : 8'(phase_heads[p]);
			first_v = (phase_first[p] < 0) ? 1'($urandom_range(0, 1)) : 1'(phase_first[p]);
			set_geometry(spt_v, heads_v, first_v);
			if (p < 3) begin
				send_idle_pct = 36;
				recv_idle_pct = 68;
			end else if (p < 6) begin
				send_idle_pct = 68;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == PRESSURE_PHASE) begin
				// Results are held back while requests keep coming, so the block
				// fills its output and staging registers and stops taking requests.
				rsp_hold = HOLD_CYCLES;
				saved_pct = send_idle_pct;
				send_idle_pct = 0;
				repeat (10)
					send_request(mk_req(OP_TRANSLATE, pick_lba(), 1'($urandom_range(0, 1)),
						16'($urandom), 1'($urandom_range(0, 1))));
				send_idle_pct = saved_pct;
			end
			run_traffic(phase_items[p]);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d expected results never arrived", sb.pending());
		$display("Sent %0d requests over %0d geometry settings, with three idling modes",
			sent, NUM_PHASES + 1);
		$display("and one long hold-off; %0d results checked, %0d seeks, codes %0d/%0d/%0d/%0d.",
			sb.checked, sb.seeks, sb.rc_count[0], sb.rc_count[1], sb.rc_count[2],
			sb.rc_count[3]);
		if (sb.faults == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d faults found", sb.faults);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
